// ----- design/insertion_sorter_with_counts_top_defines.svh -----
// ----------------------------------------------------------------------------
// insertion sorter assertion macros
// concurrent assertion helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_WITH_COUNTS_TOP_DEFINES_SVH
`define INSERTION_SORTER_WITH_COUNTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property check on the rising clock edge, off while reset is held
`define ISC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression that must never be true
`define ISC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ISC_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define ISC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- design/isc_pkg.sv -----
// ----------------------------------------------------------------------------
// insertion sorter package
// shared widths and the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch incoming value and start position
    logic rd_prev;    // read entry below the insertion position
    logic shift;      // move read entry up one place, count it
    logic place;      // write value at insertion position
    logic emit_rd;    // read entry at output index
    logic emit_load;  // load output register
    logic emit_next;  // advance output index
    logic clear_set;  // empty the store and counters
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;       // store holds the maximum number of entries
    logic pos_zero;   // insertion position at the bottom
    logic greater;    // read entry orders after the value
    logic last_q;     // captured value closes the set
    logic out_last;   // output register holds the final result
  } sts_t;

endpackage

// ----- design/isc_dp.sv -----
// ----------------------------------------------------------------------------
// insertion sorter datapath
// sorted store memory, insertion pointer, saturating counters, output register
// ----------------------------------------------------------------------------
`include "insertion_sorter_with_counts_top_defines.svh"

module isc_dp #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  isc_pkg::cmd_t                cmd_i,
  output isc_pkg::sts_t                sts_o,
  input  logic [isc_pkg::VALUE_W-1:0]  in_value_i,
  input  logic                         in_last_i,
  output logic [isc_pkg::VALUE_W-1:0]  out_value_o,
  output logic                         out_last_o,
  output logic [isc_pkg::COUNT_W-1:0]  out_cmp_o,
  output logic [isc_pkg::COUNT_W-1:0]  out_swap_o
);
  import isc_pkg::*;

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(MAX_ELEMENTS);

  logic [VALUE_W-1:0] store_mem [MAX_ELEMENTS];
  logic [VALUE_W-1:0] rd_data_q;

  logic [CW-1:0]      fill_q, fill_d;
  logic [COUNT_W-1:0] cmp_q, cmp_d;
  logic [COUNT_W-1:0] swap_q, swap_d;
  logic [AW-1:0]      pos_q;
  logic [AW-1:0]      idx_q;
  logic               moved_q;
  logic [VALUE_W-1:0] val_q;
  logic               last_q;

  logic [VALUE_W-1:0] out_value_q;
  logic               out_last_q;
  logic [COUNT_W-1:0] out_cmp_q;
  logic [COUNT_W-1:0] out_swap_q;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [COUNT_W:0]   swap_sum;
  logic               emit_last;

  assign rd_en   = cmd_i.rd_prev | cmd_i.emit_rd;
  assign rd_addr = cmd_i.emit_rd ? idx_q : (pos_q - AW'(1));
  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_addr = pos_q;
  assign wr_data = cmd_i.shift ? rd_data_q : val_q;

  // the first shift also counts the move of the value itself
  assign swap_sum  = {1'b0, swap_q} + (moved_q ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));
  assign emit_last = (CW'(idx_q) == (fill_q - CW'(1)));

  always_comb begin
    fill_d = fill_q;
    cmp_d  = cmp_q;
    swap_d = swap_q;
    if (cmd_i.clear_set) begin
      fill_d = '0;
      cmp_d  = '0;
      swap_d = '0;
    end else begin
      if (cmd_i.place) begin
        fill_d = fill_q + CW'(1);
      end
      if (cmd_i.shift) begin
        cmp_d  = (cmp_q == COUNT_MAX) ? COUNT_MAX : (cmp_q + COUNT_W'(1));
        swap_d = (swap_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : swap_sum[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cmp_q  <= '0;
      swap_q <= '0;
    end else begin
      fill_q <= fill_d;
      cmp_q  <= cmp_d;
      swap_q <= swap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q   <= in_value_i;
      last_q  <= in_last_i;
      pos_q   <= fill_q[AW-1:0];
      moved_q <= 1'b0;
      idx_q   <= '0;
    end
    if (cmd_i.shift) begin
      pos_q   <= pos_q - AW'(1);
      moved_q <= 1'b1;
    end
    if (cmd_i.emit_next) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.emit_load) begin
      out_value_q <= rd_data_q;
      out_last_q  <= emit_last;
      out_cmp_q   <= cmp_q;
      out_swap_q  <= swap_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign sts_o.full     = (fill_q == FILL_MAX);
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.greater  = ($signed(rd_data_q) > $signed(val_q));
  assign sts_o.last_q   = last_q;
  assign sts_o.out_last = out_last_q;

  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_cmp_o   = out_cmp_q;
  assign out_swap_o  = out_swap_q;

  `ISC_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_MAX, "store fill beyond capacity")
  `ISC_ASSERT_NEVER(a_rw_clash, clk_i, rst_ni, rd_en && wr_en, "store read and write in one cycle")
  `ISC_ASSERT(a_place_fill, clk_i, rst_ni, cmd_i.place |=> fill_q == $past(fill_q) + CW'(1),
              "placement did not grow the store")

endmodule

// ----- design/isc_ctrl.sv -----
// ----------------------------------------------------------------------------
// insertion sorter controller
// sequences capture, compare and shift steps, then the read-out of the set
// ----------------------------------------------------------------------------
`include "insertion_sorter_with_counts_top_defines.svh"

module isc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output isc_pkg::cmd_t cmd_o,
  input  isc_pkg::sts_t sts_i
);
  import isc_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_EMIT_RD = 3'd3;
  localparam logic [2:0] ST_EMIT_LD = 3'd4;
  localparam logic [2:0] ST_EMIT_WT = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!sts_i.full) begin
            state_d = ST_INS_RD;
          end else if (in_last_i) begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts_i.pos_zero) begin
          cmd_o.place = 1'b1;
          state_d     = sts_i.last_q ? ST_EMIT_RD : ST_IDLE;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = ST_INS_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = sts_i.last_q ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_load = 1'b1;
        state_d         = ST_EMIT_WT;
      end
      ST_EMIT_WT: begin
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT_WT);

  `ISC_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o,
                    "input and output open together")
  `ISC_ASSERT(a_set_done, clk_i, rst_ni, out_valid_o && out_ready_i && sts_i.out_last |=> in_ready_o,
              "input not reopened after final result")

endmodule

// ----- design/insertion_sorter_with_counts_top.sv -----
// ----------------------------------------------------------------------------
// insertion sorter with counts
// sorts a set of signed values, then streams it out with compare and swap counts
// ----------------------------------------------------------------------------
// channel  direction  tdata                                      tlast
// s_axis   in         [31:0] element_value                       last_element
// m_axis   out        [31:0] sorted_value, [43:32] comparison,   last_result
//                     [55:44] swap count
//
// an item that shifts stored entries is paced by the single-port store: each
// step reads one entry and then writes it one place up
// read-out reads, loads and then offers each result in turn, waiting on any output stall
// reset empties the store and clears both counters; no clearing pass is needed
// input is held off from the last item of a set until its final result transfers
// ----------------------------------------------------------------------------
module insertion_sorter_with_counts_top #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] element_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] sorted_value, [43:32] comparison_count,
                                      // [55:44] swap_count
  output logic        m_axis_tlast
);
  import isc_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0] out_cmp;
  logic [COUNT_W-1:0] out_swap;

  isc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  isc_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_value_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_cmp_o   (out_cmp),
    .out_swap_o  (out_swap)
  );

  assign m_axis_tdata = {out_swap, out_cmp, out_value};

endmodule
